@@ rtl/umrc_pkg.sv @@
// Shared types and constants for the usable memory range check block.
package umrc_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam logic [1:0]  ACT_CLEAR   = 2'd0;
    localparam logic [1:0]  ACT_APPEND  = 2'd1;
    localparam logic [1:0]  ACT_QUERY   = 2'd2;
    localparam logic [31:0] USABLE_CODE = 32'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [31:0] region_type;
        logic [31:0] region_attr;
        logic [63:0] range_start;
        logic [63:0] range_end;
    } req_t;

    typedef struct packed {
        logic        present;
        logic [63:0] top_of_memory;
        logic        status;
    } rsp_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] end_addr;
        logic        usable;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

@@ rtl/umrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module umrc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/usable_memory_range_check_top.sv @@
// Top level of the usable memory range check: region table and coverage walker.
//
// Request channel (req_valid, req_stall, req) carries one transaction per item:
// clear the region table, append a region, or query whether [range_start,
// range_end) is wholly covered by usable regions. Response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one transaction per request, in order.
// Clear, append, unused actions and queries rejected up front (empty range,
// empty table, range beyond the usable top) answer in the cycle after acceptance.
// A query that needs the walk reads the region RAM one entry per cycle through
// its single read port: each pass issues n reads for n stored regions, waits
// for the registered read data, then evaluates. Each pass moves the cursor to
// a new region end, so a walk needs at most n passes before the response is
// loaded in the done state.
// One item is in flight at a time; req_stall is high while a query walks.
// A finished response waits in an output register; while it is stalled
// req_stall stays high and no new request is taken.
// Reset empties the table (count and usable top return to zero); the RAM
// contents need no clearing since only entries below the count are read.
module usable_memory_range_check_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  umrc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output umrc_pkg::rsp_t rsp
);

    umrc_pkg::state_t state_reg, state_next;

    logic [umrc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [63:0]                top_reg, top_next;
    logic [63:0]                cursor_reg, cursor_next;
    logic [63:0]                hi_reg, hi_next;
    logic [63:0]                reach_reg, reach_next;
    logic                       hit_reg, hit_next;
    logic [umrc_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       issue_done_reg, issue_done_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       last_vld_reg, last_vld_next;
    logic [umrc_pkg::CNT_W-1:0] pass_reg, pass_next;
    logic                       present_reg, present_next;
    umrc_pkg::rsp_t             rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                        accept;
    logic                        out_free;
    logic                        load_rsp;
    logic                        full;
    logic                        start_scan;
    logic                        eval_finish;
    logic                        last_issue;
    logic [64:0]                 sum;
    logic [63:0]                 new_end;
    logic                        new_usable;
    logic                        wr_en;
    umrc_pkg::entry_t            wr_entry;
    umrc_pkg::entry_t            rd_entry;
    logic [umrc_pkg::ENTRY_W-1:0] rd_data;
    logic                        match;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != umrc_pkg::ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == umrc_pkg::CNT_W'(umrc_pkg::MAX_REGIONS));

    assign sum        = {1'b0, req.region_base} + {1'b0, req.region_length};
    assign new_end    = sum[64] ? {64{1'b1}} : sum[63:0];
    assign new_usable = (req.region_type == umrc_pkg::USABLE_CODE)
                        && (req.region_attr == umrc_pkg::USABLE_CODE);

    assign start_scan = accept && (req.action == umrc_pkg::ACT_QUERY)
                        && (req.range_start < req.range_end)
                        && (count_reg != '0)
                        && (req.range_start < top_reg)
                        && (req.range_end <= top_reg);

    assign eval_finish = !hit_reg || (reach_reg >= hi_reg)
                         || (pass_reg == umrc_pkg::CNT_W'(umrc_pkg::MAX_REGIONS));

    assign last_issue = (umrc_pkg::CNT_W'(rd_idx_reg) == count_reg - umrc_pkg::CNT_W'(1));

    assign wr_en             = accept && (req.action == umrc_pkg::ACT_APPEND) && !full;
    assign wr_entry.base     = req.region_base;
    assign wr_entry.end_addr = new_end;
    assign wr_entry.usable   = new_usable;

    umrc_ram #(
        .WIDTH  (umrc_pkg::ENTRY_W),
        .DEPTH  (umrc_pkg::MAX_REGIONS),
        .ADDR_W (umrc_pkg::IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[umrc_pkg::IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_entry = rd_data;
    assign match    = rd_entry.usable && (rd_entry.base <= cursor_reg)
                      && (rd_entry.end_addr > cursor_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            umrc_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = umrc_pkg::ST_SCAN;
                end
            end
            umrc_pkg::ST_SCAN:
            begin
                if (rd_vld_reg && last_vld_reg)
                begin
                    state_next = umrc_pkg::ST_EVAL;
                end
            end
            umrc_pkg::ST_EVAL:
            begin
                state_next = eval_finish ? umrc_pkg::ST_DONE : umrc_pkg::ST_SCAN;
            end
            umrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = umrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = umrc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next      = count_reg;
        top_next        = top_reg;
        cursor_next     = cursor_reg;
        hi_next         = hi_reg;
        reach_next      = reach_reg;
        hit_next        = hit_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        last_vld_next   = 1'b0;
        pass_next       = pass_reg;
        present_next    = present_reg;
        load_rsp        = 1'b0;
        rsp_next        = rsp_reg;

        case (state_reg)
            umrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load_rsp               = 1'b1;
                    rsp_next.present       = 1'b0;
                    rsp_next.top_of_memory = top_reg;
                    rsp_next.status        = 1'b0;
                    case (req.action)
                        umrc_pkg::ACT_CLEAR:
                        begin
                            count_next             = '0;
                            top_next               = '0;
                            rsp_next.top_of_memory = '0;
                        end
                        umrc_pkg::ACT_APPEND:
                        begin
                            if (full)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + umrc_pkg::CNT_W'(1);
                                if (new_usable && (new_end > top_reg))
                                begin
                                    top_next               = new_end;
                                    rsp_next.top_of_memory = new_end;
                                end
                            end
                        end
                        umrc_pkg::ACT_QUERY:
                        begin
                            if (start_scan)
                            begin
                                load_rsp        = 1'b0;
                                cursor_next     = req.range_start;
                                hi_next         = req.range_end;
                                reach_next      = req.range_start;
                                hit_next        = 1'b0;
                                rd_idx_next     = '0;
                                issue_done_next = 1'b0;
                                pass_next       = '0;
                            end
                        end
                        default:
                        begin
                            rsp_next.present = 1'b0;
                        end
                    endcase
                end
            end
            umrc_pkg::ST_SCAN:
            begin
                // Issue one read per cycle until the last stored entry.
                if (!issue_done_reg)
                begin
                    rd_vld_next   = 1'b1;
                    last_vld_next = last_issue;
                    if (last_issue)
                    begin
                        issue_done_next = 1'b1;
                        rd_idx_next     = '0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + umrc_pkg::IDX_W'(1);
                    end
                end
                // Fold returned entry into the furthest reach from the cursor.
                if (rd_vld_reg && match)
                begin
                    hit_next = 1'b1;
                    if (rd_entry.end_addr > reach_reg)
                    begin
                        reach_next = rd_entry.end_addr;
                    end
                end
            end
            umrc_pkg::ST_EVAL:
            begin
                if (!hit_reg)
                begin
                    present_next = 1'b0;
                end
                else if (reach_reg >= hi_reg)
                begin
                    present_next = 1'b1;
                end
                else if (eval_finish)
                begin
                    present_next = 1'b0;
                end
                else
                begin
                    // Advance the cursor and start another pass.
                    cursor_next     = reach_reg;
                    hit_next        = 1'b0;
                    issue_done_next = 1'b0;
                    rd_idx_next     = '0;
                    pass_next       = pass_reg + umrc_pkg::CNT_W'(1);
                end
            end
            umrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    load_rsp               = 1'b1;
                    rsp_next.present       = present_reg;
                    rsp_next.top_of_memory = top_reg;
                    rsp_next.status        = 1'b0;
                end
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase

        rsp_valid_next = load_rsp ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= umrc_pkg::ST_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            last_vld_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            last_vld_reg   <= last_vld_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg  <= cursor_next;
        hi_reg      <= hi_next;
        reach_reg   <= reach_next;
        hit_reg     <= hit_next;
        rd_idx_reg  <= rd_idx_next;
        pass_reg    <= pass_next;
        present_reg <= present_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != umrc_pkg::ST_IDLE) |-> req_stall)
        else $error("request accepted while a query walk is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= umrc_pkg::CNT_W'(umrc_pkg::MAX_REGIONS))
        else $error("region count exceeds table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == umrc_pkg::ST_SCAN) |-> (count_reg != '0))
        else $error("walk started on an empty table");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == umrc_pkg::ST_SCAN))
        else $error("table read data returned outside the walk");

    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == umrc_pkg::ST_EVAL) && hit_reg) |-> (reach_reg > cursor_reg))
        else $error("walk pass hit a region without advancing");

endmodule
